// ===== rtl/core/mjfe_pkg.sv =====
// Package for the motion-JPEG frame extractor: marker codes, queue sizing and
// the queue entry type shared by the front parser, the queue and the back end.
// Depends on nothing.
package mjfe_pkg;

  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_SOI = 8'hD8;
  localparam logic [7:0] BYTE_EOI = 8'hD9;
  localparam logic [7:0] BYTE_COM = 8'hFE;
  localparam logic [7:0] BYTE_TAG = 8'h01;

  localparam logic [31:0] NS_PER_HUNDREDTH = 32'd10000000;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = PTR_W + 1;

  // One queued action: a start entry expands to the two start-marker beats.
  typedef struct packed {
    logic        start;
    logic [7:0]  data;
    logic        last;
    logic        stamp_valid;
    logic [31:0] seconds;
    logic [7:0]  hundredths;
  } entry_t;

endpackage

// ===== rtl/core/mjfe_front.sv =====
// Front parser of the motion-JPEG frame extractor: accepts stream bytes,
// tracks markers and the timestamp comment, and pushes beats into the queue.
// Depends on mjfe_pkg.
module mjfe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        stream_byte,
  input  logic              full,
  output logic              push,
  output mjfe_pkg::entry_t  push_entry
);

  localparam logic [2:0] PH_HUNT       = 3'd0;
  localparam logic [2:0] PH_HUNT_FF    = 3'd1;
  localparam logic [2:0] PH_BODY       = 3'd2;
  localparam logic [2:0] PH_BODY_FF    = 3'd3;
  localparam logic [2:0] PH_COMMENT    = 3'd4;
  localparam logic [2:0] PH_SECONDS    = 3'd5;
  localparam logic [2:0] PH_HUNDREDTHS = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [1:0]  byte_count, byte_count_next;
  logic [31:0] seconds_acc, seconds_acc_next;
  logic [31:0] held_seconds, held_seconds_next;
  logic [7:0]  held_hundredths, held_hundredths_next;
  logic        held_valid, held_valid_next;
  logic        accept;
  logic        emit;
  logic        emit_start;
  logic        emit_last;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    seconds_acc_next     = seconds_acc;
    held_seconds_next    = held_seconds;
    held_hundredths_next = held_hundredths;
    held_valid_next      = held_valid;
    emit                 = 1'b0;
    emit_start           = 1'b0;
    emit_last            = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (stream_byte == mjfe_pkg::BYTE_FF) phase_next = PH_HUNT_FF;
      end
      PH_HUNT_FF: begin
        if (stream_byte == mjfe_pkg::BYTE_SOI) begin
          emit                 = 1'b1;
          emit_start           = 1'b1;
          held_valid_next      = 1'b0;
          held_seconds_next    = '0;
          held_hundredths_next = '0;
          phase_next           = PH_BODY;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_BODY: begin
        emit = 1'b1;
        if (stream_byte == mjfe_pkg::BYTE_FF) phase_next = PH_BODY_FF;
      end
      PH_BODY_FF: begin
        emit = 1'b1;
        if (stream_byte == mjfe_pkg::BYTE_EOI) begin
          emit_last  = 1'b1;
          phase_next = PH_HUNT;
        end else if (stream_byte == mjfe_pkg::BYTE_COM) begin
          byte_count_next = '0;
          phase_next      = PH_COMMENT;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_COMMENT: begin
        emit = 1'b1;
        if (byte_count == 2'd3) begin
          byte_count_next = '0;
          if (stream_byte == mjfe_pkg::BYTE_TAG) begin
            seconds_acc_next = '0;
            phase_next       = PH_SECONDS;
          end else begin
            phase_next = PH_BODY;
          end
        end else begin
          byte_count_next = byte_count + 2'd1;
        end
      end
      PH_SECONDS: begin
        emit             = 1'b1;
        seconds_acc_next = {seconds_acc[23:0], stream_byte};
        if (byte_count == 2'd3) begin
          byte_count_next = '0;
          phase_next      = PH_HUNDREDTHS;
        end else begin
          byte_count_next = byte_count + 2'd1;
        end
      end
      PH_HUNDREDTHS: begin
        emit                 = 1'b1;
        held_seconds_next    = seconds_acc;
        held_hundredths_next = stream_byte;
        held_valid_next      = 1'b1;
        phase_next           = PH_BODY;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // Stamp fields ride only on the end-of-frame beat.
  always_comb begin
    push_entry.start       = emit_start;
    push_entry.data        = stream_byte;
    push_entry.last        = emit_last;
    push_entry.stamp_valid = emit_last && held_valid;
    push_entry.seconds     = emit_last ? held_seconds : '0;
    push_entry.hundredths  = emit_last ? held_hundredths : '0;
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      byte_count      <= '0;
      seconds_acc     <= '0;
      held_seconds    <= '0;
      held_hundredths <= '0;
      held_valid      <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      seconds_acc     <= seconds_acc_next;
      held_seconds    <= held_seconds_next;
      held_hundredths <= held_hundredths_next;
      held_valid      <= held_valid_next;
    end
  end

endmodule

// ===== rtl/core/mjfe_queue.sv =====
// Short register queue between the front parser and the back end.
// Depends on mjfe_pkg.
module mjfe_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mjfe_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output mjfe_pkg::entry_t  head,
  output logic              empty
);

  mjfe_pkg::entry_t                slots [mjfe_pkg::QUEUE_DEPTH];
  logic [mjfe_pkg::PTR_W-1:0]      wr_ptr;
  logic [mjfe_pkg::PTR_W-1:0]      rd_ptr;
  logic [mjfe_pkg::COUNT_W-1:0]    count;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (count == mjfe_pkg::COUNT_W'(mjfe_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + mjfe_pkg::PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + mjfe_pkg::PTR_W'(1);
      if (do_push && !do_pop)      count <= count + mjfe_pkg::COUNT_W'(1);
      else if (do_pop && !do_push) count <= count - mjfe_pkg::COUNT_W'(1);
    end
  end

endmodule

// ===== rtl/core/mjfe_back.sv =====
// Back end of the motion-JPEG frame extractor: drains the queue into the
// output register, splitting start entries into two beats. Depends on mjfe_pkg.
module mjfe_back (
  input  logic              clk,
  input  logic              rst,
  input  mjfe_pkg::entry_t  head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        frame_byte,
  output logic              end_of_frame,
  output logic              stamp_valid,
  output logic [31:0]       stamp_seconds,
  output logic [31:0]       stamp_nanoseconds
);

  logic load;
  logic first_half;
  logic half_done;

  assign load       = !empty && (!out_valid || !out_stall);
  assign first_half = head.start && !half_done;
  assign pop        = load && !first_half;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half_done <= 1'b0;
    end else begin
      if (load)            out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (load) half_done <= first_half;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte        <= first_half ? mjfe_pkg::BYTE_FF : head.data;
      end_of_frame      <= head.last;
      stamp_valid       <= head.stamp_valid;
      stamp_seconds     <= head.seconds;
      stamp_nanoseconds <= 32'(head.hundredths) * mjfe_pkg::NS_PER_HUNDREDTH;
    end
  end

endmodule

// ===== rtl/core/mjpeg_frame_extractor.sv =====
// Motion-JPEG frame extractor, top level: front parser, queue and back end.
// Depends on mjfe_pkg, mjfe_front, mjfe_queue and mjfe_back.
//
// Input channel: one raw stream byte per beat on stream_byte, handshaken by
// in_valid and in_stall. Output channel: one frame byte per beat with its
// end_of_frame flag and timestamp, handshaken by out_valid and out_stall.
// Bytes outside a frame are dropped; the FF D8 start marker opens a frame and
// both its bytes are sent; every later byte passes until FF D9, whose D9 beat
// carries end_of_frame and the timestamp of the last FF FE ... 01 comment.
// Stamp fields read zero on every other beat.
// An accepted byte is written into a queue slot and from there into the output
// register, from which the receiver takes it.
// Throughput: one byte per cycle while in_stall is low; the start marker costs one
// extra output beat, absorbed by the four-entry queue between front and back.
// When the receiver stalls, the output beat holds, the queue fills, and once
// it is full in_stall rises until the back end drains an entry.
// Reset clears the parser to hunting for FF, the held timestamp, the queue and
// the output valid; payload registers are left as they are.
module mjpeg_frame_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  frame_byte,
  output logic        end_of_frame,
  output logic        stamp_valid,
  output logic [31:0] stamp_seconds,
  output logic [31:0] stamp_nanoseconds
);

  mjfe_pkg::entry_t push_entry;
  mjfe_pkg::entry_t head;
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;

  // Parse markers and comments; push one entry per frame byte, one start entry for FF D8.
  mjfe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .stream_byte (stream_byte),
    .full        (full),
    .push        (push),
    .push_entry  (push_entry)
  );

  // Decouple the parser from output back-pressure.
  mjfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  // Expand and register output beats, scaling hundredths to nanoseconds.
  mjfe_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .empty             (empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .frame_byte        (frame_byte),
    .end_of_frame      (end_of_frame),
    .stamp_valid       (stamp_valid),
    .stamp_seconds     (stamp_seconds),
    .stamp_nanoseconds (stamp_nanoseconds)
  );

endmodule

// ===== verif/mjpeg_frame_extractor_tb.sv =====
// Self-checking testbench for mjpeg_frame_extractor: directed and random byte streams
// checked beat by beat against an in-bench frame parser.
// Depends on mjfe_pkg and the mjpeg_frame_extractor RTL.
`timescale 1ns / 1ps

module mjpeg_frame_extractor_tb;

  localparam int RANDOM_BYTES    = 1950;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 4000;
  localparam int TAIL_CYCLES     = 8;
  localparam int HOLD_OFF_AT     = 400;
  localparam int PAUSE_AT        = 700;
  localparam int CALM_FROM       = 1000;
  localparam int CALM_TO         = 1300;

  // One output beat as the block should present it.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        stamp_valid;
    logic [31:0] seconds;
    logic [31:0] nanoseconds;
  } frame_beat_t;

  // Directed stimulus row: typed rows carry their expectation (or none) by hand.
  typedef struct packed {
    logic [7:0]  stream;
    logic        typed;
    logic        has_beat;
    frame_beat_t beat;
  } stim_row_t;

  typedef enum logic [2:0] {
    SEEK, SEEK_FF, IN_FRAME, IN_FRAME_FF, COMMENT_HDR, STAMP_SECS, STAMP_HUND
  } parser_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  stream_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  frame_byte;
  logic        end_of_frame;
  logic        stamp_valid;
  logic [31:0] stamp_seconds;
  logic [31:0] stamp_nanoseconds;

  // Parser state mirrored in the bench; reset is applied once, so start at reset values.
  parser_phase_t phase = SEEK;
  logic [1:0]    tally = 2'd0;
  logic [31:0]   secs_acc = '0;
  logic [31:0]   held_secs = '0;
  logic [7:0]    held_hund = '0;
  logic          held_valid = 1'b0;

  frame_beat_t beats_due[$];
  logic [7:0]  stream_plan[$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_off_pending = 1'b0;

  // Start marker, a stray FF before it, a max-valued stamp, FF D8 as data, and a
  // frame with no stamp at all.
  stim_row_t directed_rows [25] = '{
    '{mjfe_pkg::BYTE_FF,  1'b1, 1'b0, '0},
    '{mjfe_pkg::BYTE_FF,  1'b1, 1'b0, '0},   // consumed as the byte after FF
    '{mjfe_pkg::BYTE_SOI, 1'b1, 1'b0, '0},   // so this D8 is only hunted over
    '{mjfe_pkg::BYTE_FF,  1'b1, 1'b0, '0},
    '{mjfe_pkg::BYTE_SOI, 1'b0, 1'b0, '0},
    '{8'h00,              1'b0, 1'b0, '0},
    '{mjfe_pkg::BYTE_FF,  1'b0, 1'b0, '0},
    '{mjfe_pkg::BYTE_COM, 1'b0, 1'b0, '0},
    '{8'h10,              1'b0, 1'b0, '0},
    '{8'h20,              1'b0, 1'b0, '0},
    '{8'h30,              1'b0, 1'b0, '0},
    '{mjfe_pkg::BYTE_TAG, 1'b0, 1'b0, '0},
    '{8'hFF,              1'b0, 1'b0, '0},
    '{8'hFF,              1'b0, 1'b0, '0},
    '{8'hFF,              1'b0, 1'b0, '0},
    '{8'hFF,              1'b0, 1'b0, '0},
    '{8'hFF,              1'b0, 1'b0, '0},
    '{mjfe_pkg::BYTE_FF,  1'b0, 1'b0, '0},
    '{mjfe_pkg::BYTE_SOI, 1'b0, 1'b0, '0},
    '{mjfe_pkg::BYTE_FF,  1'b0, 1'b0, '0},
    '{mjfe_pkg::BYTE_EOI, 1'b1, 1'b1,
      '{mjfe_pkg::BYTE_EOI, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd2550000000}},
    '{mjfe_pkg::BYTE_FF,  1'b1, 1'b0, '0},
    '{mjfe_pkg::BYTE_SOI, 1'b0, 1'b0, '0},
    '{mjfe_pkg::BYTE_FF,  1'b0, 1'b0, '0},
    '{mjfe_pkg::BYTE_EOI, 1'b1, 1'b1,
      '{mjfe_pkg::BYTE_EOI, 1'b1, 1'b0, 32'h0, 32'h0}}
  };

  mjpeg_frame_extractor i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .stream_byte       (stream_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .frame_byte        (frame_byte),
    .end_of_frame      (end_of_frame),
    .stamp_valid       (stamp_valid),
    .stamp_seconds     (stamp_seconds),
    .stamp_nanoseconds (stamp_nanoseconds)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Queue one expected beat; the stamp only rides on the end-of-frame beat.
  function automatic void push_beat(input logic [7:0] data, input logic last);
    frame_beat_t beat;
    beat = '0;
    beat.data = data;
    beat.last = last;
    if (last) begin
      beat.stamp_valid = held_valid;
      beat.seconds     = held_secs;
      beat.nanoseconds = 32'(held_hund) * mjfe_pkg::NS_PER_HUNDREDTH;
    end
    beats_due = {beats_due, beat};
  endfunction

  // Advance the frame parser by one accepted stream byte and queue its beats.
  function automatic void track_stream_byte(input logic [7:0] b);
    case (phase)
      SEEK: begin
        if (b == mjfe_pkg::BYTE_FF) phase = SEEK_FF;
      end
      SEEK_FF: begin
        if (b == mjfe_pkg::BYTE_SOI) begin
          // New frame: drop any stamp left from the previous one.
          held_valid = 1'b0;
          held_secs  = '0;
          held_hund  = '0;
          push_beat(mjfe_pkg::BYTE_FF, 1'b0);
          push_beat(mjfe_pkg::BYTE_SOI, 1'b0);
          phase = IN_FRAME;
        end else begin
          phase = SEEK;
        end
      end
      IN_FRAME: begin
        push_beat(b, 1'b0);
        if (b == mjfe_pkg::BYTE_FF) phase = IN_FRAME_FF;
      end
      IN_FRAME_FF: begin
        if (b == mjfe_pkg::BYTE_EOI) begin
          push_beat(b, 1'b1);
          phase = SEEK;
        end else begin
          push_beat(b, 1'b0);
          if (b == mjfe_pkg::BYTE_COM) begin
            tally = 2'd0;
            phase = COMMENT_HDR;
          end else begin
            phase = IN_FRAME;
          end
        end
      end
      COMMENT_HDR: begin
        push_beat(b, 1'b0);
        if (tally == 2'd3) begin
          tally = 2'd0;
          if (b == mjfe_pkg::BYTE_TAG) begin
            secs_acc = '0;
            phase = STAMP_SECS;
          end else begin
            phase = IN_FRAME;
          end
        end else begin
          tally = tally + 2'd1;
        end
      end
      STAMP_SECS: begin
        push_beat(b, 1'b0);
        secs_acc = {secs_acc[23:0], b};
        if (tally == 2'd3) begin
          tally = 2'd0;
          phase = STAMP_HUND;
        end else begin
          tally = tally + 2'd1;
        end
      end
      STAMP_HUND: begin
        push_beat(b, 1'b0);
        held_secs  = secs_acc;
        held_hund  = b;
        held_valid = 1'b1;
        phase = IN_FRAME;
      end
      default: phase = SEEK;
    endcase
  endfunction

  // Append one byte to the planned stream.
  function automatic void plan_byte(input logic [7:0] b);
    stream_plan = {stream_plan, b};
  endfunction

  // Plan one stretch of stream: some junk, a frame opening, a body of mixed
  // chunks and, mostly, a closing marker. A few openings and closings are broken.
  function automatic void plan_frame();
    int chunks;
    int pick;
    logic [7:0] tag;
    repeat ($urandom_range(0, 4)) plan_byte(8'($urandom_range(0, 255)));
    plan_byte(mjfe_pkg::BYTE_FF);
    if ($urandom_range(0, 9) == 0) plan_byte(8'($urandom_range(0, 255)));
    else plan_byte(mjfe_pkg::BYTE_SOI);
    chunks = $urandom_range(1, 12);
    repeat (chunks) begin
      pick = $urandom_range(0, 7);
      if (pick <= 4) begin
        plan_byte(8'($urandom_range(0, 255)));
      end else if (pick == 5) begin
        plan_byte(mjfe_pkg::BYTE_FF);
        plan_byte(mjfe_pkg::BYTE_COM);
        repeat (3) plan_byte(8'($urandom_range(0, 255)));
        tag = ($urandom_range(0, 3) != 0) ? mjfe_pkg::BYTE_TAG : 8'($urandom_range(0, 255));
        plan_byte(tag);
        if (tag == mjfe_pkg::BYTE_TAG) begin
          // Seconds bytes lean towards the extremes now and then.
          repeat (4) begin
            pick = $urandom_range(0, 7);
            plan_byte(pick == 0 ? 8'h00 :
                      pick == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
          end
          plan_byte(8'($urandom_range(0, 255)));
        end
      end else if (pick == 6) begin
        plan_byte(mjfe_pkg::BYTE_FF);
        plan_byte(mjfe_pkg::BYTE_SOI);
      end else begin
        plan_byte(mjfe_pkg::BYTE_FF);
        plan_byte(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      plan_byte(mjfe_pkg::BYTE_FF);
      plan_byte(mjfe_pkg::BYTE_EOI);
    end
  endfunction

  // Offer one byte, idling first at random; return at the edge that takes the beat.
  task automatic offer_byte(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stimulus: reset, directed rows, then the planned random stream.
  initial begin
    int base;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      offer_byte(directed_rows[r].stream);
      base = beats_due.size();
      track_stream_byte(directed_rows[r].stream);
      if (directed_rows[r].typed) begin
        // Replace what the parser queued with the hand-typed expectation.
        while (beats_due.size() > base) void'(beats_due.pop_back());
        if (directed_rows[r].has_beat) beats_due = {beats_due, directed_rows[r].beat};
      end
    end

    while (stream_plan.size() < RANDOM_BYTES) plan_frame();

    for (int i = 0; i < stream_plan.size(); i++) begin
      if (i == HOLD_OFF_AT) hold_off_pending = 1'b1;
      if (i == PAUSE_AT) begin
        // Hold the stream until the block has drained every beat owed.
        in_valid <= 1'b0;
        do @(posedge clk); while (beats_due.size() != 0);
      end
      calm = (i >= CALM_FROM && i < CALM_TO);
      offer_byte(stream_plan[i]);
      track_stream_byte(stream_plan[i]);
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    do @(posedge clk); while (beats_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, none while calm, and one long hold-off on request
  // so that the queue fills and the input side is stalled.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_stall <= (!calm && $urandom_range(0, 99) < 33);
    end
  end

  // Check every accepted output beat against the oldest beat owed.
  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (beats_due.size() == 0) begin
        $error("unexpected beat: frame_byte %0h end_of_frame %0b", frame_byte, end_of_frame);
        mismatch_count++;
      end else begin
        want = beats_due.pop_front();
        if (frame_byte !== want.data) begin
          $error("frame_byte: expected %0h, got %0h", want.data, frame_byte);
          mismatch_count++;
        end
        if (end_of_frame !== want.last) begin
          $error("end_of_frame: expected %0b, got %0b", want.last, end_of_frame);
          mismatch_count++;
        end
        if (stamp_valid !== want.stamp_valid) begin
          $error("stamp_valid: expected %0b, got %0b", want.stamp_valid, stamp_valid);
          mismatch_count++;
        end
        if (stamp_seconds !== want.seconds) begin
          $error("stamp_seconds: expected %0h, got %0h", want.seconds, stamp_seconds);
          mismatch_count++;
        end
        if (stamp_nanoseconds !== want.nanoseconds) begin
          $error("stamp_nanoseconds: expected %0d, got %0d",
                 want.nanoseconds, stamp_nanoseconds);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
